@@ rtl/q2rm_pkg.sv @@
// Shared types and constants for the quaternion to rotation matrix block.
// No dependencies; used by quaternion_to_rotation_matrix_top.
package q2rm_pkg;

    localparam int IN_W      = 16;            // component width
    localparam int OUT_W     = 16;            // Q1.14 entry width
    localparam int PROD_W    = 2 * IN_W;      // signed product width
    localparam int NUM_W     = PROD_W + 2;    // signed numerator width
    localparam int DEN_W     = PROD_W + 1;    // unsigned sum of squares width
    localparam int MAG_W     = DEN_W;         // numerator magnitude width
    localparam int Q_W       = 16;            // raw quotient bits (scale 2^15)
    localparam int N_LANES   = 9;             // matrix entries
    localparam int N_PROD    = 10;            // distinct component products
    localparam int DIV_STEPS = Q_W;           // one quotient bit per stage

    localparam logic signed [OUT_W-1:0] Q_ONE = OUT_W'(16384);

    // product slots
    localparam int P_WW = 0;
    localparam int P_XX = 1;
    localparam int P_YY = 2;
    localparam int P_ZZ = 3;
    localparam int P_WX = 4;
    localparam int P_WY = 5;
    localparam int P_WZ = 6;
    localparam int P_XY = 7;
    localparam int P_XZ = 8;
    localparam int P_YZ = 9;

    typedef struct packed {
        logic signed [IN_W-1:0] quat_w;
        logic signed [IN_W-1:0] quat_x;
        logic signed [IN_W-1:0] quat_y;
        logic signed [IN_W-1:0] quat_z;
    } quat_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] east_from_bx;
        logic signed [OUT_W-1:0] east_from_by;
        logic signed [OUT_W-1:0] east_from_bz;
        logic signed [OUT_W-1:0] north_from_bx;
        logic signed [OUT_W-1:0] north_from_by;
        logic signed [OUT_W-1:0] north_from_bz;
        logic signed [OUT_W-1:0] down_from_bx;
        logic signed [OUT_W-1:0] down_from_by;
        logic signed [OUT_W-1:0] down_from_bz;
        logic                    zero_input;
    } rot_out_t;

endpackage

@@ rtl/quaternion_to_rotation_matrix_top.sv @@
// Quaternion to East-North-Down rotation matrix, fully pipelined.
// Depends on q2rm_pkg (types, widths, product slots).
//
// Usage:
//   s_valid/s_ready/s_data carry one quaternion item (four signed 16-bit
//   components of any common scale). m_valid/m_ready/m_data carry one result
//   item: nine Q1.14 entries, each round(16384 * num / n2) with ties away
//   from zero, and zero_input when all components are zero (identity used).
// Throughput: one item per cycle when the receiver does not stall. Each item
//   passes through every stage listed below before m_valid rises.
// Structure: input register, product stage (ten 16x16 multiplies), sum stage
//   (nine numerators and n2), then 16 restoring-divide stages that each
//   resolve one quotient bit for all nine lanes, a round/sign stage and an
//   output register. Depth is set by the one-bit-per-stage divider.
// Stall: a two-entry output (register plus skid) holds results; the pipe
//   advances whenever the skid entry is empty, so s_ready depends only on
//   registered state and no item is lost or repeated.
// Reset: aresetn (sync, active low) clears all valid bits; payload
//   registers are not reset.
module quaternion_to_rotation_matrix_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  q2rm_pkg::quat_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output q2rm_pkg::rot_out_t  m_data
);

    localparam int L  = q2rm_pkg::N_LANES;
    localparam int DS = q2rm_pkg::DIV_STEPS;

    logic adv;   // whole pipe advances

    // stage 0: input register
    logic               in_v_reg;
    q2rm_pkg::quat_in_t in_d_reg;

    // stage 1: products
    logic                                 pr_v_reg;
    logic signed [q2rm_pkg::PROD_W-1:0]   prod_reg [q2rm_pkg::N_PROD];
    logic signed [q2rm_pkg::PROD_W-1:0]   prod_next [q2rm_pkg::N_PROD];

    // stage 2: numerators and sum of squares
    logic                                 sm_v_reg;
    logic                                 sm_zero_reg;
    logic        [q2rm_pkg::DEN_W-1:0]    sm_n2_reg;
    logic signed [q2rm_pkg::NUM_W-1:0]    num_reg  [L];
    logic signed [q2rm_pkg::NUM_W-1:0]    num_next [L];
    logic        [q2rm_pkg::DEN_W-1:0]    n2_next;

    // divide stages
    logic                                 dv_v_reg    [DS];
    logic                                 dv_zero_reg [DS];
    logic        [q2rm_pkg::DEN_W-1:0]    dv_n2_reg   [DS];
    logic        [q2rm_pkg::MAG_W-1:0]    rem_reg     [DS][L];
    logic        [q2rm_pkg::Q_W-1:0]      quo_reg     [DS][L];
    logic                                 neg_reg     [DS][L];
    logic        [q2rm_pkg::MAG_W-1:0]    rem_next    [DS][L];
    logic        [q2rm_pkg::Q_W-1:0]      quo_next    [DS][L];

    // round/sign stage
    logic                                 rs_v_reg;
    q2rm_pkg::rot_out_t                   rs_d_reg;
    q2rm_pkg::rot_out_t                   rs_d_next;
    logic signed [q2rm_pkg::OUT_W-1:0]    ent_next [L];

    // output register and skid
    logic                                 m_valid_reg;
    q2rm_pkg::rot_out_t                   m_data_reg;
    logic                                 skid_valid_reg;
    q2rm_pkg::rot_out_t                   skid_data_reg;

    assign adv     = !skid_valid_reg;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // products
    always_comb begin
        prod_next[q2rm_pkg::P_WW] = in_d_reg.quat_w * in_d_reg.quat_w;
        prod_next[q2rm_pkg::P_XX] = in_d_reg.quat_x * in_d_reg.quat_x;
        prod_next[q2rm_pkg::P_YY] = in_d_reg.quat_y * in_d_reg.quat_y;
        prod_next[q2rm_pkg::P_ZZ] = in_d_reg.quat_z * in_d_reg.quat_z;
        prod_next[q2rm_pkg::P_WX] = in_d_reg.quat_w * in_d_reg.quat_x;
        prod_next[q2rm_pkg::P_WY] = in_d_reg.quat_w * in_d_reg.quat_y;
        prod_next[q2rm_pkg::P_WZ] = in_d_reg.quat_w * in_d_reg.quat_z;
        prod_next[q2rm_pkg::P_XY] = in_d_reg.quat_x * in_d_reg.quat_y;
        prod_next[q2rm_pkg::P_XZ] = in_d_reg.quat_x * in_d_reg.quat_z;
        prod_next[q2rm_pkg::P_YZ] = in_d_reg.quat_y * in_d_reg.quat_z;
    end

    // numerators, all in NUM_W signed
    logic signed [q2rm_pkg::NUM_W-1:0] ew, ex, ey, ez, ewx, ewy, ewz, exy, exz, eyz;
    always_comb begin
        ew  = q2rm_pkg::NUM_W'(prod_reg[q2rm_pkg::P_WW]);
        ex  = q2rm_pkg::NUM_W'(prod_reg[q2rm_pkg::P_XX]);
        ey  = q2rm_pkg::NUM_W'(prod_reg[q2rm_pkg::P_YY]);
        ez  = q2rm_pkg::NUM_W'(prod_reg[q2rm_pkg::P_ZZ]);
        ewx = q2rm_pkg::NUM_W'(prod_reg[q2rm_pkg::P_WX]);
        ewy = q2rm_pkg::NUM_W'(prod_reg[q2rm_pkg::P_WY]);
        ewz = q2rm_pkg::NUM_W'(prod_reg[q2rm_pkg::P_WZ]);
        exy = q2rm_pkg::NUM_W'(prod_reg[q2rm_pkg::P_XY]);
        exz = q2rm_pkg::NUM_W'(prod_reg[q2rm_pkg::P_XZ]);
        eyz = q2rm_pkg::NUM_W'(prod_reg[q2rm_pkg::P_YZ]);
        num_next[0] = (exy + ewz) <<< 1;
        num_next[1] = ew + ey - ex - ez;
        num_next[2] = (eyz - ewx) <<< 1;
        num_next[3] = ew + ex - ey - ez;
        num_next[4] = (exy - ewz) <<< 1;
        num_next[5] = (exz + ewy) <<< 1;
        num_next[6] = (exz - ewy) <<< 1;
        num_next[7] = (eyz + ewx) <<< 1;
        num_next[8] = ew + ez - ex - ey;
        n2_next     = q2rm_pkg::DEN_W'(ew + ex + ey + ez);
    end

    // restoring divide: first stage takes the magnitude, later ones shift in
    logic [q2rm_pkg::MAG_W-1:0] mag0 [L];
    logic [q2rm_pkg::MAG_W:0]   part [DS][L];
    logic                       qbit [DS][L];
    always_comb begin
        for (int ln = 0; ln < L; ln++) begin
            mag0[ln] = num_reg[ln][q2rm_pkg::NUM_W-1] ?
                       q2rm_pkg::MAG_W'(-num_reg[ln]) : q2rm_pkg::MAG_W'(num_reg[ln]);
            part[0][ln] = {1'b0, mag0[ln]};
            qbit[0][ln] = part[0][ln] >= {1'b0, sm_n2_reg};
            rem_next[0][ln] = qbit[0][ln] ?
                q2rm_pkg::MAG_W'(part[0][ln] - {1'b0, sm_n2_reg}) :
                q2rm_pkg::MAG_W'(part[0][ln]);
            quo_next[0][ln] = q2rm_pkg::Q_W'(qbit[0][ln]);
        end
        for (int st = 1; st < DS; st++) begin
            for (int ln = 0; ln < L; ln++) begin
                part[st][ln] = {rem_reg[st-1][ln], 1'b0};
                qbit[st][ln] = part[st][ln] >= {1'b0, dv_n2_reg[st-1]};
                rem_next[st][ln] = qbit[st][ln] ?
                    q2rm_pkg::MAG_W'(part[st][ln] - {1'b0, dv_n2_reg[st-1]}) :
                    q2rm_pkg::MAG_W'(part[st][ln]);
                quo_next[st][ln] = {quo_reg[st-1][ln][q2rm_pkg::Q_W-2:0], qbit[st][ln]};
            end
        end
    end

    // round half away from zero, apply sign, identity for the zero case
    logic [q2rm_pkg::Q_W:0]      rnd [L];
    logic [q2rm_pkg::OUT_W-1:0]  rmag [L];
    always_comb begin
        for (int ln = 0; ln < L; ln++) begin
            rnd[ln]  = {1'b0, quo_reg[DS-1][ln]} + (q2rm_pkg::Q_W+1)'(1);
            rmag[ln] = rnd[ln][q2rm_pkg::Q_W:1];
            ent_next[ln] = neg_reg[DS-1][ln] ? -$signed(rmag[ln]) : $signed(rmag[ln]);
            if (dv_zero_reg[DS-1]) begin
                ent_next[ln] = (ln == 1 || ln == 3 || ln == 8) ? q2rm_pkg::Q_ONE : '0;
            end
        end
        rs_d_next.east_from_bx  = ent_next[0];
        rs_d_next.east_from_by  = ent_next[1];
        rs_d_next.east_from_bz  = ent_next[2];
        rs_d_next.north_from_bx = ent_next[3];
        rs_d_next.north_from_by = ent_next[4];
        rs_d_next.north_from_bz = ent_next[5];
        rs_d_next.down_from_bx  = ent_next[6];
        rs_d_next.down_from_by  = ent_next[7];
        rs_d_next.down_from_bz  = ent_next[8];
        rs_d_next.zero_input    = dv_zero_reg[DS-1];
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
            pr_v_reg <= 1'b0;
            sm_v_reg <= 1'b0;
            rs_v_reg <= 1'b0;
            for (int st = 0; st < DS; st++) begin
                dv_v_reg[st] <= 1'b0;
            end
        end else if (adv) begin
            in_v_reg    <= s_valid;
            pr_v_reg    <= in_v_reg;
            sm_v_reg    <= pr_v_reg;
            dv_v_reg[0] <= sm_v_reg;
            for (int st = 1; st < DS; st++) begin
                dv_v_reg[st] <= dv_v_reg[st-1];
            end
            rs_v_reg <= dv_v_reg[DS-1];
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            in_d_reg <= s_data;
            for (int p = 0; p < q2rm_pkg::N_PROD; p++) begin
                prod_reg[p] <= prod_next[p];
            end
            for (int ln = 0; ln < L; ln++) begin
                num_reg[ln] <= num_next[ln];
            end
            sm_n2_reg   <= n2_next;
            sm_zero_reg <= (n2_next == '0);
            dv_n2_reg[0]   <= sm_n2_reg;
            dv_zero_reg[0] <= sm_zero_reg;
            for (int ln = 0; ln < L; ln++) begin
                rem_reg[0][ln] <= rem_next[0][ln];
                quo_reg[0][ln] <= quo_next[0][ln];
                neg_reg[0][ln] <= num_reg[ln][q2rm_pkg::NUM_W-1];
            end
            for (int st = 1; st < DS; st++) begin
                dv_n2_reg[st]   <= dv_n2_reg[st-1];
                dv_zero_reg[st] <= dv_zero_reg[st-1];
                for (int ln = 0; ln < L; ln++) begin
                    rem_reg[st][ln] <= rem_next[st][ln];
                    quo_reg[st][ln] <= quo_next[st][ln];
                    neg_reg[st][ln] <= neg_reg[st-1][ln];
                end
            end
            rs_d_reg <= rs_d_next;
        end
    end

    // output register with skid entry
    logic take;
    assign take = rs_v_reg && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= take;
            end
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : rs_d_reg;
        end
        if (m_valid_reg && !m_ready && take) begin
            skid_data_reg <= rs_d_reg;
        end
    end

endmodule
